/* rtl/core/vrd_pkg.sv */
`default_nettype none

package vrd_pkg;

  localparam int FRAME_COUNT_BITS = 25;
  localparam int MAX_BYTES_BITS = 24;
  localparam logic [MAX_BYTES_BITS-1:0] MAX_FRAME_BYTES_RESET = 24'd524288;

  typedef enum logic [3:0] {
    PH_FLAGS,
    PH_PID1,
    PH_PID2,
    PH_SS,
    PH_SSWH,
    PH_SSNG,
    PH_SSGRP,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_STARTED,
    ST_SEQ_GAP,
    ST_TRUNCATED,
    ST_LF_UNSUPPORTED,
    ST_LAYERS_UNSUPPORTED,
    ST_TOO_LARGE
  } status_t;

  typedef struct packed {
    logic pid;
    logic g;
    logic y;
    logic v;
    logic b;
  } flags_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_of_packet;
    logic        last_of_packet;
    logic [15:0] seq_number;
    logic        marker_bit;
  } item_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        frame_byte_valid;
    logic        frame_restart;
    logic        packet_done;
    status_t     packet_status;
    logic        frame_complete;
    logic        frame_abort;
    logic [14:0] picture_id;
    logic        picture_id_valid;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/vrd_core.sv */
`default_nettype none

module vrd_core (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   advance,
  input  vrd_pkg::item_t                        item,
  input  wire [vrd_pkg::MAX_BYTES_BITS-1:0]     max_frame_bytes,
  output vrd_pkg::result_t                      res
);
  import vrd_pkg::*;

  localparam int CMP_W = (FRAME_COUNT_BITS > MAX_BYTES_BITS) ? FRAME_COUNT_BITS
                                                              : MAX_BYTES_BITS;

  phase_t                      phase, phase_next;
  flags_t                      flags, flags_next;
  logic [14:0]                 pid, pid_next;
  logic [8:0]                  skip, skip_next;
  status_t                     err, err_next;
  logic                        started, started_next;
  logic [15:0]                 last_seq, last_seq_next;
  logic [FRAME_COUNT_BITS-1:0] count, count_next;
  logic [15:0]                 held_seq, held_seq_next;

  always_comb begin
    phase_t            ph;
    logic              done;
    logic [8:0]        dec;
    logic [7:0]        b;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  max_ext;
    ph = item.first_of_packet ? PH_FLAGS : phase;
    b = item.payload_byte;
    dec = skip - 9'd1;
    done = 1'b0;
    phase_next = ph;
    flags_next = flags;
    pid_next = pid;
    skip_next = skip;
    err_next = err;
    started_next = started;
    last_seq_next = last_seq;
    count_next = count;
    held_seq_next = held_seq;
    res = '0;

    unique case (ph)
      PH_FLAGS: begin
        held_seq_next = item.seq_number;
        err_next = ST_OK;
        pid_next = '0;
        flags_next = '0;
        skip_next = '0;
        if (b[5] || b[4]) begin
          err_next = ST_LF_UNSUPPORTED;
          phase_next = PH_DISCARD;
        end else begin
          flags_next.b = b[3];
          flags_next.v = b[1];
          if (b[7]) phase_next = PH_PID1;
          else if (b[1]) phase_next = PH_SS;
          else done = 1'b1;
        end
      end
      PH_PID1: begin
        if (b[7]) begin
          pid_next = {b[6:0], 8'h00};
          phase_next = PH_PID2;
        end else begin
          pid_next = {8'h00, b[6:0]};
          flags_next.pid = 1'b1;
          if (flags.v) phase_next = PH_SS;
          else done = 1'b1;
        end
      end
      PH_PID2: begin
        pid_next = pid | {7'h00, b};
        flags_next.pid = 1'b1;
        if (flags.v) phase_next = PH_SS;
        else done = 1'b1;
      end
      PH_SS: begin
        if (b[7:5] != 3'd0) begin
          err_next = ST_LAYERS_UNSUPPORTED;
          phase_next = PH_DISCARD;
        end else begin
          flags_next.y = flags.y | b[4];
          flags_next.g = flags.g | b[3];
          if (flags_next.y) begin
            skip_next = 9'd4;
            phase_next = PH_SSWH;
          end else if (flags_next.g) begin
            phase_next = PH_SSNG;
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_SSWH: begin
        skip_next = dec;
        if (dec == 9'd0) begin
          if (flags.g) phase_next = PH_SSNG;
          else done = 1'b1;
        end
      end
      PH_SSNG: begin
        if (b == 8'd0) begin
          done = 1'b1;
        end else begin
          // two bytes per group entry
          skip_next = {b, 1'b0};
          phase_next = PH_SSGRP;
        end
      end
      PH_SSGRP: begin
        skip_next = dec;
        if (dec == 9'd0) done = 1'b1;
      end
      PH_PAYLOAD: begin
        res.frame_byte = b;
        res.frame_byte_valid = 1'b1;
        if (count != '1) count_next = count + 1'b1;
      end
      default: begin
      end
    endcase

    // descriptor complete: start and continuity checks
    if (done) begin
      if (flags_next.b) begin
        res.frame_restart = started;
        count_next = '0;
        started_next = 1'b1;
        last_seq_next = held_seq_next;
        phase_next = PH_PAYLOAD;
      end else if (!started) begin
        err_next = ST_NOT_STARTED;
        phase_next = PH_DISCARD;
      end else if (held_seq_next - last_seq != 16'd1) begin
        err_next = ST_SEQ_GAP;
        count_next = '0;
        started_next = 1'b0;
        phase_next = PH_DISCARD;
      end else begin
        last_seq_next = held_seq_next;
        phase_next = PH_PAYLOAD;
      end
    end

    count_ext = CMP_W'(count_next);
    max_ext = CMP_W'(max_frame_bytes);

    if (item.last_of_packet) begin
      res.packet_done = 1'b1;
      if (phase_next == PH_PAYLOAD) begin
        if (item.marker_bit) begin
          res.frame_complete = 1'b1;
          count_next = '0;
          started_next = 1'b0;
        end else if (count_ext > max_ext) begin
          res.packet_status = ST_TOO_LARGE;
          res.frame_abort = 1'b1;
          err_next = ST_TOO_LARGE;
          count_next = '0;
          started_next = 1'b0;
        end
      end else if (phase_next == PH_DISCARD) begin
        res.packet_status = err_next;
        res.frame_abort = (err_next == ST_SEQ_GAP);
      end else begin
        res.packet_status = ST_TRUNCATED;
        err_next = ST_TRUNCATED;
      end
      phase_next = PH_FLAGS;
    end

    if (flags_next.pid) begin
      res.picture_id = pid_next;
      res.picture_id_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLAGS;
      flags <= '0;
      pid <= '0;
      skip <= '0;
      err <= ST_OK;
      started <= 1'b0;
      last_seq <= '0;
      count <= '0;
      held_seq <= '0;
    end else if (advance) begin
      phase <= phase_next;
      flags <= flags_next;
      pid <= pid_next;
      skip <= skip_next;
      err <= err_next;
      started <= started_next;
      last_seq <= last_seq_next;
      count <= count_next;
      held_seq <= held_seq_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vp9_rtp_depacketizer.sv */
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    payload_byte, packet flags, seq_number, marker_bit
// out       output     out_valid / out_ready  frame byte, packet status, frame events, picture id
// cfg       input      cfg_wr_en              cfg_wr_data (max_frame_bytes)
//
// one byte per cycle sustained while out_ready is high; input register, then result register
// parser state updates as a byte moves from the input register into the result register
// rst is synchronous; max_frame_bytes returns to 524288 and the parser to the flags byte
// a stalled result holds the result register; the input register still takes a byte
// while the result waits, then in_ready drops until the result is taken

module vp9_rtp_depacketizer (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [7:0]  payload_byte,
  input  wire        first_of_packet,
  input  wire        last_of_packet,
  input  wire [15:0] seq_number,
  input  wire        marker_bit,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] frame_byte,
  output logic       frame_byte_valid,
  output logic       frame_restart,
  output logic       packet_done,
  output logic [2:0] packet_status,
  output logic       frame_complete,
  output logic       frame_abort,
  output logic [14:0] picture_id,
  output logic       picture_id_valid,
  input  wire        cfg_wr_en,
  input  wire [23:0] cfg_wr_data
);
  import vrd_pkg::*;

  logic                      in_v;
  item_t                     item_r;
  logic                      advance;
  result_t                   res;
  result_t                   res_r;
  logic [MAX_BYTES_BITS-1:0] max_frame_bytes;

  assign advance  = in_v && (!out_valid || out_ready);
  assign in_ready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ready) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{payload_byte: payload_byte, first_of_packet: first_of_packet,
                  last_of_packet: last_of_packet, seq_number: seq_number,
                  marker_bit: marker_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_BYTES_RESET;
    end else if (cfg_wr_en) begin
      max_frame_bytes <= cfg_wr_data;
    end
  end

  vrd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .item            (item_r),
    .max_frame_bytes (max_frame_bytes),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign frame_byte       = res_r.frame_byte;
  assign frame_byte_valid = res_r.frame_byte_valid;
  assign frame_restart    = res_r.frame_restart;
  assign packet_done      = res_r.packet_done;
  assign packet_status    = res_r.packet_status;
  assign frame_complete   = res_r.frame_complete;
  assign frame_abort      = res_r.frame_abort;
  assign picture_id       = res_r.picture_id;
  assign picture_id_valid = res_r.picture_id_valid;

  // an empty result register never backs up the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result register");

  // status only reported at packet end
  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_done |-> packet_status == ST_OK && !frame_complete && !frame_abort)
    else $error("packet end event without packet_done");

  a_abort_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_abort |-> packet_status == ST_SEQ_GAP || packet_status == ST_TOO_LARGE)
    else $error("frame abort with unexpected status");

  a_complete_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_complete |-> packet_status == ST_OK && !frame_abort)
    else $error("frame complete with error status");

endmodule

`default_nettype wire
